/* src/rfrc_pkg.sv */
// shared types, constants and crc helper for the radio frame receive checker
package rfrc_pkg;

  localparam int unsigned HdrBytes = 8;
  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  Bcast    = 8'hFF;
  localparam logic [7:0]  CntMax   = 8'hFF;

  // header byte positions
  localparam logic [2:0] PosMagic   = 3'd0;
  localparam logic [2:0] PosType    = 3'd1;
  localparam logic [2:0] PosEventHi = 3'd2;
  localparam logic [2:0] PosEventLo = 3'd3;
  localparam logic [2:0] PosStation = 3'd4;
  localparam logic [2:0] PosSeqHi   = 3'd5;
  localparam logic [2:0] PosSeqLo   = 3'd6;
  localparam logic [2:0] PosLen     = 3'd7;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StShort   = 3'd1,
    StMagic   = 3'd2,
    StLength  = 3'd3,
    StCrc     = 3'd4,
    StEvent   = 3'd5,
    StStation = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    CfgMagic   = 2'd0,
    CfgEvent   = 2'd1,
    CfgStation = 2'd2
  } cfg_idx_e;

  localparam logic KindPayload = 1'b0;
  localparam logic KindVerdict = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  value;
    logic [7:0]  index;
    status_e     status;
    logic [7:0]  ptype;
    logic [15:0] seq;
    logic [7:0]  len;
  } result_t;

  typedef struct packed {
    logic [7:0]  magic;
    logic [15:0] evt;
    logic [7:0]  station;
  } cfg_t;

  // crc-16/ccitt-false, one byte, msb first
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* src/radio_frame_rx_checker.sv */
// top level of the radio frame receive checker
//
//  channel | signals                                   | moves
//  --------+-------------------------------------------+----------------------------
//  in      | in_valid_i / in_ready_o                   | one frame byte per request
//  out     | out_valid_o / out_ready_i                 | payload byte or verdict
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i          | register write, no wait
//
// one byte per cycle sustained while out_ready_i stays high: a byte waits in the
// input register, then the frame logic (byte-wide crc update and verdict compare)
// writes the result register.
// reset clears the frame state (crc to 0xffff) and the configuration registers.
// a stalled result holds the result register; the input register keeps taking a
// byte while the result waits, so the input side stalls only when both are full.
module radio_frame_rx_checker import rfrc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // byte input
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_end_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_value_o,
  output logic [7:0]  payload_index_o,
  output logic [2:0]  status_o,
  output logic [7:0]  pkt_type_o,
  output logic [15:0] pkt_seq_o,
  output logic [7:0]  pkt_payload_len_o
);

  cfg_t       cfg_q;
  logic       held_valid;
  logic [7:0] held_byte;
  logic       held_last;
  logic       advance;
  logic       res_valid;
  result_t    res;
  logic       out_valid_q;
  result_t    out_q;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgMagic:   cfg_q.magic    <= cfg_wdata_i[7:0];
        CfgEvent:   cfg_q.evt      <= cfg_wdata_i;
        CfgStation: cfg_q.station  <= cfg_wdata_i[7:0];
        default:    cfg_q          <= cfg_q;
      endcase
    end
  end

  // the held byte moves on whenever the result slot is free or draining
  assign advance = held_valid && (!out_valid_q || out_ready_i);

  rfrc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .frame_end_i (frame_end_i),
    .take_i      (advance),
    .valid_o     (held_valid),
    .byte_o      (held_byte),
    .last_o      (held_last)
  );

  rfrc_frame_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .byte_i      (held_byte),
    .last_i      (held_last),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_q.kind;
  assign payload_value_o   = out_q.value;
  assign payload_index_o   = out_q.index;
  assign status_o          = out_q.status;
  assign pkt_type_o        = out_q.ptype;
  assign pkt_seq_o         = out_q.seq;
  assign pkt_payload_len_o = out_q.len;

`ifndef SYNTH
  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !advance)
    else $error("result overwritten while stalled");
  // input stalls only when the held byte cannot move
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> held_valid && out_valid_q && !out_ready_i)
    else $error("input stalled without cause");
  // a step that gives a result shows it the next cycle
  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_valid |=> out_valid_q)
    else $error("result lost");
`endif

endmodule

/* src/rfrc_in_reg.sv */
// input register stage of the radio frame receive checker
module rfrc_in_reg import rfrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       frame_end_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  output logic       last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
      last_q <= frame_end_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
  assign last_o  = last_q;

`ifndef SYNTH
  a_take_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("take without a held byte");
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && $stable(byte_q) && $stable(last_q))
    else $error("held byte lost while stalled");
  a_full_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |-> !in_ready_o)
    else $error("ready while full and not draining");
`endif

endmodule

/* src/rfrc_frame_core.sv */
// frame state, header capture, crc and verdict logic
module rfrc_frame_core import rfrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  logic [7:0]  cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_end_q, crc_end_d;
  logic [15:0] rcv_crc_q, rcv_crc_d;
  logic [7:0]  magic_q, magic_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] event_q, event_d;
  logic [7:0]  station_q, station_d;
  logic [15:0] seq_q, seq_d;
  logic [7:0]  len_q, len_d;

  logic        sat, in_hdr, in_pay, crc_hi, crc_lo, fwd;
  logic [8:0]  p9, pay_end;
  logic [15:0] crc_next;
  logic [7:0]  n;
  status_e     st;

  assign sat      = (cnt_q == CntMax);
  assign in_hdr   = (cnt_q < 8'(HdrBytes));
  assign p9       = {1'b0, cnt_q};
  assign crc_next = crc_byte(crc_q, byte_i);

  always_comb begin
    magic_d   = magic_q;
    type_d    = type_q;
    event_d   = event_q;
    station_d = station_q;
    seq_d     = seq_q;
    len_d     = len_q;
    if (!sat && in_hdr) begin
      case (cnt_q[2:0])
        PosMagic:   magic_d   = byte_i;
        PosType:    type_d    = byte_i;
        PosEventHi: event_d   = {byte_i, event_q[7:0]};
        PosEventLo: event_d   = {event_q[15:8], byte_i};
        PosStation: station_d = byte_i;
        PosSeqHi:   seq_d     = {byte_i, seq_q[7:0]};
        PosSeqLo:   seq_d     = {seq_q[15:8], byte_i};
        PosLen:     len_d     = byte_i;
        default:    len_d     = len_q;
      endcase
    end
  end

  assign pay_end = 9'(HdrBytes) + {1'b0, len_d};
  assign in_pay  = !in_hdr && (p9 < pay_end);
  assign crc_hi  = !in_hdr && (p9 == pay_end);
  assign crc_lo  = !in_hdr && (p9 == pay_end + 9'd1);
  assign fwd     = !sat && in_pay;

  always_comb begin
    crc_d     = crc_q;
    crc_end_d = crc_end_q;
    rcv_crc_d = rcv_crc_q;
    cnt_d     = cnt_q;
    if (!sat) begin
      if (in_hdr || in_pay) begin
        crc_d = crc_next;
      end
      if (crc_hi) begin
        rcv_crc_d = {byte_i, rcv_crc_q[7:0]};
      end
      if (crc_lo) begin
        rcv_crc_d = {rcv_crc_q[15:8], byte_i};
      end
      if (p9 + 9'd1 == pay_end) begin
        crc_end_d = crc_d;
      end
      cnt_d = cnt_q + 8'd1;
    end
  end

  assign n = cnt_d;

  always_comb begin
    if (n < 8'(HdrBytes + 2)) begin
      st = StShort;
    end else if (magic_d != cfg_i.magic) begin
      st = StMagic;
    end else if ((10'(HdrBytes + 2) + {2'b00, len_d}) > {2'b00, n}) begin
      st = StLength;
    end else if (rcv_crc_d != crc_end_d) begin
      st = StCrc;
    end else if (event_d != cfg_i.evt) begin
      st = StEvent;
    end else if (station_d != cfg_i.station && station_d != Bcast) begin
      st = StStation;
    end else begin
      st = StOk;
    end
  end

  always_comb begin
    res_o = '0;
    if (last_i) begin
      res_o.kind   = KindVerdict;
      res_o.status = st;
      res_o.ptype  = type_d;
      res_o.seq    = seq_d;
      res_o.len    = len_d;
    end else begin
      res_o.kind   = KindPayload;
      res_o.status = StOk;
      res_o.value  = byte_i;
      res_o.index  = cnt_q - 8'(HdrBytes);
    end
  end

  assign res_valid_o = step_i && (last_i || fwd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      crc_q     <= CrcInit;
      crc_end_q <= '0;
      rcv_crc_q <= '0;
      magic_q   <= '0;
      type_q    <= '0;
      event_q   <= '0;
      station_q <= '0;
      seq_q     <= '0;
      len_q     <= '0;
    end else if (step_i) begin
      if (last_i) begin
        cnt_q     <= '0;
        crc_q     <= CrcInit;
        crc_end_q <= '0;
        rcv_crc_q <= '0;
        magic_q   <= '0;
        type_q    <= '0;
        event_q   <= '0;
        station_q <= '0;
        seq_q     <= '0;
        len_q     <= '0;
      end else begin
        cnt_q     <= cnt_d;
        crc_q     <= crc_d;
        crc_end_q <= crc_end_d;
        rcv_crc_q <= rcv_crc_d;
        magic_q   <= magic_d;
        type_q    <= type_d;
        event_q   <= event_d;
        station_q <= station_d;
        seq_q     <= seq_d;
        len_q     <= len_d;
      end
    end
  end

`ifndef SYNTH
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> cnt_q == '0 && crc_q == CrcInit)
    else $error("frame state not cleared after frame end");
  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !last_i && !sat |=> cnt_q == $past(cnt_q) + 8'd1)
    else $error("byte count did not advance");
  a_fwd_past_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.kind == KindPayload |-> !in_hdr && !sat)
    else $error("payload forwarded from header or saturated frame");
`endif

endmodule

/* verif/tb_top.sv */
// self-checking testbench for the radio frame receive checker
module tb_top import rfrc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // run limits: the watchdog is far above the slowest legal run
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned DrainGuard  = 5000;
  localparam int unsigned PhaseBytes  = 75;

  typedef logic [7:0] byte_q_t[$];

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, all known from time zero
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  rx_byte_i   = '0;
  logic        frame_end_i = 1'b0;
  logic        out_ready_i = 1'b0;

  // block outputs
  logic        in_ready_o;
  logic        out_valid_o;
  logic        result_kind_o;
  logic [7:0]  payload_value_o;
  logic [7:0]  payload_index_o;
  logic [2:0]  status_o;
  logic [7:0]  pkt_type_o;
  logic [15:0] pkt_seq_o;
  logic [7:0]  pkt_payload_len_o;

  // idle pressure of the current phase, in percent of cycles
  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;

  // predicted results, oldest first
  result_t expected_results[$];
  result_t exp_r;

  // mirror of the configuration registers (reset value zero)
  logic [7:0]  cur_magic   = '0;
  logic [15:0] cur_event   = '0;
  logic [7:0]  cur_station = '0;

  // mirror of the frame state
  logic [7:0]  cnt      = '0;
  logic [15:0] crc_run  = CrcInit;
  logic [15:0] crc_pay  = '0;
  logic [15:0] crc_rx   = '0;
  logic [7:0]  h_magic  = '0;
  logic [7:0]  h_type   = '0;
  logic [15:0] h_event  = '0;
  logic [7:0]  h_station = '0;
  logic [15:0] h_seq    = '0;
  logic [7:0]  h_len    = '0;

  radio_frame_rx_checker i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .frame_end_i       (frame_end_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_kind_o     (result_kind_o),
    .payload_value_o   (payload_value_o),
    .payload_index_o   (payload_index_o),
    .status_o          (status_o),
    .pkt_type_o        (pkt_type_o),
    .pkt_seq_o         (pkt_seq_o),
    .pkt_payload_len_o (pkt_payload_len_o)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver side: random back-pressure at the phase's stall rate
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // crc-16/ccitt-false, bit-serial form, msb first
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return c;
  endfunction

  // back to the post-reset frame state, configuration untouched
  function automatic void clear_frame_state();
    cnt       = '0;
    crc_run   = CrcInit;
    crc_pay   = '0;
    crc_rx    = '0;
    h_magic   = '0;
    h_type    = '0;
    h_event   = '0;
    h_station = '0;
    h_seq     = '0;
    h_len     = '0;
  endfunction

  // advance the frame mirror by one accepted byte and queue what it causes
  function automatic void track_byte(input logic [7:0] b, input logic last);
    result_t     r;
    logic [7:0]  p;
    int unsigned pay_end;
    int unsigned n;
    logic        fwd;
    r   = '0;
    p   = cnt;
    fwd = 1'b0;
    // once the count sits at its ceiling, further bytes change nothing
    if (cnt != CntMax) begin
      pay_end = HdrBytes + h_len;
      if (p < HdrBytes) begin
        case (p[2:0])
          PosMagic:   h_magic        = b;
          PosType:    h_type         = b;
          PosEventHi: h_event[15:8]  = b;
          PosEventLo: h_event[7:0]   = b;
          PosStation: h_station      = b;
          PosSeqHi:   h_seq[15:8]    = b;
          PosSeqLo:   h_seq[7:0]     = b;
          PosLen:     h_len          = b;
          default:    h_len          = h_len;
        endcase
        crc_run = crc16_step(crc_run, b);
        pay_end = HdrBytes + h_len;
      end else if (p < pay_end) begin
        crc_run = crc16_step(crc_run, b);
        fwd     = 1'b1;
      end else if (p == pay_end) begin
        crc_rx[15:8] = b;
      end else if (p == pay_end + 1) begin
        crc_rx[7:0] = b;
      end
      if (p + 1 == pay_end) crc_pay = crc_run;
      cnt = cnt + 8'd1;
    end
    // the verdict wins over forwarding when the last byte is a payload byte
    if (last) begin
      n      = cnt;
      r.kind = KindVerdict;
      if (n < HdrBytes + 2)                               r.status = StShort;
      else if (h_magic != cur_magic)                      r.status = StMagic;
      else if (HdrBytes + h_len + 2 > n)                  r.status = StLength;
      else if (crc_rx != crc_pay)                         r.status = StCrc;
      else if (h_event != cur_event)                      r.status = StEvent;
      else if (h_station != cur_station && h_station != Bcast) r.status = StStation;
      else                                                r.status = StOk;
      r.ptype = h_type;
      r.seq   = h_seq;
      r.len   = h_len;
      expected_results.push_back(r);
      clear_frame_state();
    end else if (fwd) begin
      r.kind  = KindPayload;
      r.value = b;
      r.index = p - 8'(HdrBytes);
      expected_results.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // predict on every accepted request, compare every accepted result;
  // both run off the values seen at the edge, so order within the step is moot
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) track_byte(rx_byte_i, frame_end_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d status %0d",
                 result_kind_o, status_o);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("result_kind", exp_r.kind, result_kind_o);
          check_field("payload_value", exp_r.value, payload_value_o);
          check_field("payload_index", exp_r.index, payload_index_o);
          check_field("status", exp_r.status, status_o);
          check_field("pkt_type", exp_r.ptype, pkt_type_o);
          check_field("pkt_seq", exp_r.seq, pkt_seq_o);
          check_field("pkt_payload_len", exp_r.len, pkt_payload_len_o);
        end
      end
    end
  end

  // header, payload and big-endian crc; crc_xor corrupts the crc on purpose
  function automatic void build_frame(input logic [7:0] magic, input logic [7:0] ptype,
                                      input logic [15:0] ev, input logic [7:0] st,
                                      input logic [15:0] seq, input byte_q_t pay,
                                      input logic [15:0] crc_xor, output byte_q_t fr);
    logic [15:0] crc;
    fr = {magic, ptype, ev[15:8], ev[7:0], st, seq[15:8], seq[7:0], 8'(pay.size())};
    foreach (pay[i]) fr.push_back(pay[i]);
    crc = CrcInit;
    foreach (fr[i]) crc = crc16_step(crc, fr[i]);
    crc = crc ^ crc_xor;
    fr.push_back(crc[15:8]);
    fr.push_back(crc[7:0]);
  endfunction

  function automatic void rand_payload(input int unsigned len, output byte_q_t pay);
    pay = {};
    repeat (len) pay.push_back(8'($urandom));
  endfunction

  // mostly well-formed frames with random content, some cut short, some noise
  function automatic void gen_random_frame(output byte_q_t fr);
    byte_q_t     pay;
    int unsigned sel, len, cut, pick;
    logic [7:0]  magic, st;
    logic [15:0] ev, flip;
    sel = $urandom_range(99);
    if (sel >= 85) begin
      // noise: random bytes of random length
      fr = {};
      repeat ($urandom_range(16, 1)) fr.push_back(8'($urandom));
      return;
    end
    pick = $urandom_range(99);
    if (pick < 75)      len = $urandom_range(8);
    else if (pick < 95) len = $urandom_range(40, 9);
    else                len = $urandom_range(120, 41);
    rand_payload(len, pay);
    magic = ($urandom_range(19) == 0) ? 8'($urandom) : cur_magic;
    ev    = ($urandom_range(19) == 0) ? 16'($urandom) : cur_event;
    case ($urandom_range(2))
      0:       st = cur_station;
      1:       st = Bcast;
      default: st = 8'($urandom);
    endcase
    flip = ($urandom_range(19) == 0) ? (16'd1 << $urandom_range(15)) : 16'h0000;
    build_frame(magic, 8'($urandom), ev, st, 16'($urandom), pay, flip, fr);
    if (sel < 70) begin
      // trailing bytes after the crc are ignored by the block
      if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) fr.push_back(8'($urandom));
    end else begin
      cut = $urandom_range(fr.size(), 1);
      while (fr.size() > cut) void'(fr.pop_back());
    end
  endfunction

  // one request; called at a rising edge, returns at the accepting edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    rx_byte_i   <= b;
    frame_end_i <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_frame(input byte_q_t fr);
    foreach (fr[i]) send_byte(fr[i], i == fr.size() - 1);
  endtask

  // drop valid, wait out the results, then the pipeline latency
  task automatic wait_idle();
    int unsigned guard;
    guard = 0;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0 && guard < DrainGuard) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // writes all three registers back to back; only called while idle
  task automatic load_config(input logic [15:0] magic, input logic [15:0] ev,
                             input logic [15:0] st);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgMagic;
    cfg_wdata_i <= magic;
    @(posedge clk_i);
    cfg_idx_i   <= CfgEvent;
    cfg_wdata_i <= ev;
    @(posedge clk_i);
    cfg_idx_i   <= CfgStation;
    cfg_wdata_i <= st;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    // 8-bit registers keep only the low byte
    cur_magic   = magic[7:0];
    cur_event   = ev;
    cur_station = st[7:0];
  endtask

  // registers at reset value: an all-zero header passes, a lone byte is short
  task automatic test_reset_defaults();
    byte_q_t none, fr;
    none = {};
    build_frame(8'h00, 8'h00, 16'h0000, 8'h00, 16'h0000, none, 16'h0000, fr);
    send_frame(fr);
    fr = {8'hFF};
    send_frame(fr);
    wait_idle();
  endtask

  // one frame each for ok, magic, crc, event and station verdicts, in check order
  task automatic test_status_codes();
    byte_q_t none, pay, fr;
    none = {};
    // junk in the upper byte of the 8-bit registers must be dropped
    load_config(16'hC35A, 16'hBEEF, 16'hFF21);
    pay = {8'hA7};
    build_frame(8'h5A, 8'h01, 16'hBEEF, 8'h21, 16'h0001, pay, 16'h0000, fr);
    send_frame(fr);
    // bad magic still forwards its payload
    pay = {8'h11, 8'h22};
    build_frame(8'hA5, 8'h02, 16'hBEEF, 8'h21, 16'h0002, pay, 16'h0000, fr);
    send_frame(fr);
    build_frame(8'h5A, 8'h03, 16'hBEEF, 8'h21, 16'h0003, none, 16'h0001, fr);
    send_frame(fr);
    build_frame(8'h5A, 8'h04, 16'hBEEE, 8'h21, 16'h0004, none, 16'h0000, fr);
    send_frame(fr);
    build_frame(8'h5A, 8'h05, 16'hBEEF, 8'h22, 16'h0005, none, 16'h0000, fr);
    send_frame(fr);
    // broadcast station is accepted
    build_frame(8'h5A, 8'h06, 16'hBEEF, Bcast, 16'h0006, none, 16'h0000, fr);
    send_frame(fr);
    wait_idle();
  endtask

  task automatic test_special_cases();
    byte_q_t pay, fr;
    // short frame: header fields not yet seen read as zero
    fr = {8'h5A, 8'h77, 8'hBE};
    send_frame(fr);
    // frame ends inside the payload: no forward on the last byte, length verdict
    pay = {8'h01, 8'h02, 8'h03, 8'h04};
    build_frame(8'h5A, 8'h10, 16'hBEEF, 8'h21, 16'h0010, pay, 16'h0000, fr);
    while (fr.size() > HdrBytes + 2) void'(fr.pop_back());
    send_frame(fr);
    // extremes of the header and payload fields, plus trailing bytes
    pay = {8'hFF, 8'h00};
    build_frame(8'h5A, 8'hFF, 16'hBEEF, 8'h21, 16'hFFFF, pay, 16'h0000, fr);
    fr.push_back(8'hFF);
    fr.push_back(8'h00);
    send_frame(fr);
    wait_idle();
  endtask

  // frames past 255 bytes: the count saturates and later bytes are ignored
  task automatic test_saturation();
    byte_q_t pay, fr;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    rand_payload(240, pay);
    build_frame(cur_magic, 8'($urandom), cur_event, cur_station, 16'($urandom), pay,
                16'h0000, fr);
    repeat (12) fr.push_back(8'($urandom));
    send_frame(fr);
    // declared length reaches past the saturation point
    rand_payload(250, pay);
    build_frame(cur_magic, 8'($urandom), cur_event, cur_station, 16'($urandom), pay,
                16'h0000, fr);
    send_frame(fr);
    wait_idle();
  endtask

  // four idle phases, each under its own register setting
  task automatic test_random_traffic();
    byte_q_t     fr;
    int unsigned sent;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          load_config(16'($urandom), 16'($urandom), 16'($urandom));
          snd_idle_pct  = 60;
          rcv_stall_pct = 0;
        end
        2: begin
          load_config(16'h0000, 16'h0000, 16'h0000);
          snd_idle_pct  = 0;
          rcv_stall_pct = 60;
        end
        default: begin
          load_config(16'($urandom), 16'($urandom), 16'($urandom));
          snd_idle_pct  = 30;
          rcv_stall_pct = 30;
        end
      endcase
      sent = 0;
      while (sent < PhaseBytes) begin
        gen_random_frame(fr);
        send_frame(fr);
        sent += fr.size();
      end
      wait_idle();
    end
  endtask

  initial begin
    // reset held from time zero, released once
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_status_codes();
    test_special_cases();
    test_saturation();
    test_random_traffic();
    wait_idle();
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
